### hdl/round_robin_sleep_scheduler_unit_defines.svh
// ----------------------------------------------------------------------------
// round robin sleep scheduler assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_SLEEP_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_SLEEP_SCHEDULER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define RRSS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("scheduler assertion failed");
// checked on every edge, reset included
`define RRSS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("scheduler assertion failed");
`else
`define RRSS_ASSERT(lbl, clk, rstn, prop)
`define RRSS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### hdl/rrss_pkg.sv
// ----------------------------------------------------------------------------
// rrss_pkg
// shared types and constants of the round robin sleep scheduler
// ----------------------------------------------------------------------------
package rrss_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int SLEEP_W = 16;
  localparam int SLICE_W = 8;

  localparam logic [SLICE_W-1:0] SLICE_TICKS_RST = 8'd16;
  localparam logic [SLICE_W-1:0] SLICE_MAX = 8'hFF;

  // register index taken from paddr bit 2
  localparam logic REG_SLICE_TICKS = 1'b0;

  localparam logic signed [3:0] FORK_NONE = 4'sb1111;

  typedef enum logic [1:0] {
    ST_DEAD     = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_BLOCKED  = 2'd3
  } slot_state_e;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_SLEEP = 2'd1,
    ACT_EXIT  = 2'd2,
    ACT_FORK  = 2'd3
  } action_e;

  typedef struct packed {
    slot_state_e          state;
    logic [SLEEP_W-1:0]   sleep_left;
  } slot_entry_t;

endpackage

### hdl/rrss_slot_mem.sv
// ----------------------------------------------------------------------------
// rrss_slot_mem
// slot table memory, one write and one registered read port; entries not yet
// written read back as their reset value (slot 0 running, others dead)
// ----------------------------------------------------------------------------
module rrss_slot_mem
  import rrss_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IDXW = $clog2(SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [IDXW-1:0]   waddr_i,
  input  slot_entry_t       wdata_i,
  input  logic              re_i,
  input  logic [IDXW-1:0]   raddr_i,
  output slot_entry_t       rdata_o
);

  slot_entry_t       mem_q [SLOTS];
  slot_entry_t       rdata_q;
  logic [SLOTS-1:0]  valid_q;
  logic              rvalid_q;
  logic [IDXW-1:0]   raddr_q;
  slot_entry_t       rst_entry;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      raddr_q  <= '0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
        raddr_q  <= raddr_i;
      end
    end
  end

  always_comb begin
    rst_entry.state      = (raddr_q == '0) ? ST_RUNNING : ST_DEAD;
    rst_entry.sleep_left = '0;
  end

  assign rdata_o = rvalid_q ? rdata_q : rst_entry;

endmodule

### hdl/round_robin_sleep_scheduler_unit.sv
// flow: S_SWEEP walks the slot table read-modify-write through its read and
//   write ports, S_CAND makes a second write when the tick hands the slot to
//   another slot, S_DONE waits for the output register; in_stall_o holds off
//   a new transaction until the unit is back in S_IDLE
// reset: slot 0 running, all others dead, slice_ticks 16; no clearing pass,
//   per-entry valid bits make unwritten slots read as their reset value
// ----------------------------------------------------------------------------
// round_robin_sleep_scheduler_unit
// round robin time slice scheduler with sleep countdown, exit and fork
// ----------------------------------------------------------------------------
`include "round_robin_sleep_scheduler_unit_defines.svh"

module round_robin_sleep_scheduler_unit
  import rrss_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          action_i,
  input  logic [15:0]         sleep_ticks_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          running_slot_o,
  output logic                no_runnable_o,
  output logic signed [3:0]   fork_result_o,
  output logic                switched_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IDXW = $clog2(SLOTS);
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_CAND,
    S_DONE
  } state_e;

  function automatic logic [IDXW-1:0] wrap_inc(input logic [IDXW-1:0] a);
    return (a == LAST_IDX) ? '0 : a + 1'b1;
  endfunction

  state_e               state_q;
  action_e              act_q;
  logic [SLEEP_W-1:0]   req_q;
  logic [CNTW-1:0]      k_q;
  logic [IDXW-1:0]      rd_addr_q;
  logic [IDXW-1:0]      proc_addr_q;
  logic [IDXW-1:0]      cur_q;
  logic                 cur_running_q;
  logic [SLICE_W-1:0]   slice_q;
  logic [SLICE_W-1:0]   slice_ticks_q;
  logic                 found_q;
  logic [IDXW-1:0]      cand_q;
  logic [SLEEP_W-1:0]   cand_sleep_q;
  logic [2:0]           res_slot_q;
  logic                 res_no_run_q;
  logic signed [3:0]    res_fork_q;
  logic                 res_switched_q;
  logic                 out_valid_q;
  logic [2:0]           out_slot_q;
  logic                 out_no_run_q;
  logic signed [3:0]    out_fork_q;
  logic                 out_switched_q;

  // memory port
  logic                 mem_we;
  logic [IDXW-1:0]      mem_waddr;
  slot_entry_t          mem_wdata;
  logic                 mem_re;
  slot_entry_t          ent;

  // processing of the entry read in the previous cycle
  logic                 proc_en;
  logic                 is_fork;
  logic                 is_cur_pos;
  slot_state_e          st;
  slot_state_e          st_pre;
  logic [SLEEP_W-1:0]   sl;
  logic [SLICE_W-1:0]   slice_inc;
  logic                 do_switch;
  logic [IDXW-1:0]      new_cur;
  logic                 new_running;
  logic                 new_switched;
  logic                 fork_hit;
  logic                 fork_found;
  logic [IDXW-1:0]      fork_idx;
  logic [IDXW+3:0]      new_cur_ext;
  logic [IDXW+3:0]      fork_idx_ext;
  logic [IDXW+3:0]      cur_ext;
  logic                 in_accept;
  logic                 out_load;
  logic                 cfg_write;

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign is_fork = (act_q == ACT_FORK);
  assign proc_en = (state_q == S_SWEEP) && (k_q != '0);
  assign is_cur_pos = (k_q == CNT_LAST);
  assign mem_re = (state_q == S_SWEEP) && (k_q < CNT_LAST);

  rrss_slot_mem #(
    .SLOTS (SLOTS)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_addr_q),
    .rdata_o (ent)
  );

  always_comb begin
    st = ent.state;
    sl = ent.sleep_left;
    // sleep and exit touch the current slot before its countdown
    if (!is_fork && is_cur_pos && cur_running_q) begin
      case (act_q)
        ACT_SLEEP: begin
          st = ST_BLOCKED;
          sl = (req_q == '0) ? SLEEP_W'(1) : req_q;
        end
        ACT_EXIT: st = ST_DEAD;
        default: ;
      endcase
    end
    if (st == ST_BLOCKED) begin
      if (sl != '0) begin
        sl = sl - 1'b1;
      end
      if (sl == '0) begin
        st = ST_RUNNABLE;
      end
    end
  end

  assign slice_inc = (slice_q == SLICE_MAX) ? slice_q : slice_q + 1'b1;
  assign do_switch = (slice_inc >= slice_ticks_q) || (st != ST_RUNNING);
  assign st_pre = (st == ST_RUNNING) ? ST_RUNNABLE : st;
  assign new_cur = (do_switch && found_q) ? cand_q : cur_q;
  assign new_running = !do_switch || found_q || (st_pre == ST_RUNNABLE);
  assign new_switched = new_running && (!cur_running_q || (new_cur != cur_q));

  assign fork_hit = (ent.state == ST_DEAD) && !found_q;
  assign fork_found = found_q || fork_hit;
  assign fork_idx = found_q ? cand_q : proc_addr_q;

  assign new_cur_ext = (IDXW + 4)'(new_cur);
  assign fork_idx_ext = (IDXW + 4)'(fork_idx);
  assign cur_ext = (IDXW + 4)'(cur_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = proc_addr_q;
    mem_wdata = '{state: st, sleep_left: sl};
    if (state_q == S_CAND) begin
      mem_we    = 1'b1;
      mem_waddr = cand_q;
      mem_wdata = '{state: ST_RUNNING, sleep_left: cand_sleep_q};
    end else if (proc_en) begin
      if (is_fork) begin
        mem_we    = fork_hit;
        mem_wdata = '{state: ST_RUNNABLE, sleep_left: '0};
      end else begin
        mem_we = 1'b1;
        if (is_cur_pos && do_switch) begin
          if (!found_q && (st_pre == ST_RUNNABLE)) begin
            mem_wdata.state = ST_RUNNING;
          end else begin
            mem_wdata.state = st_pre;
          end
        end
      end
    end
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      act_q          <= ACT_TICK;
      req_q          <= '0;
      k_q            <= '0;
      rd_addr_q      <= '0;
      proc_addr_q    <= '0;
      cur_q          <= '0;
      cur_running_q  <= 1'b1;
      slice_q        <= '0;
      found_q        <= 1'b0;
      cand_q         <= '0;
      cand_sleep_q   <= '0;
      res_slot_q     <= '0;
      res_no_run_q   <= 1'b0;
      res_fork_q     <= '0;
      res_switched_q <= 1'b0;
      out_valid_q    <= 1'b0;
      out_slot_q     <= '0;
      out_no_run_q   <= 1'b0;
      out_fork_q     <= '0;
      out_switched_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q    <= 1'b1;
        out_slot_q     <= res_slot_q;
        out_no_run_q   <= res_no_run_q;
        out_fork_q     <= res_fork_q;
        out_switched_q <= res_switched_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (mem_re) begin
        proc_addr_q <= rd_addr_q;
        rd_addr_q   <= wrap_inc(rd_addr_q);
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            act_q     <= action_e'(action_i);
            req_q     <= sleep_ticks_i;
            k_q       <= '0;
            found_q   <= 1'b0;
            // fork scans from slot 0, the tick walk starts after the current slot
            rd_addr_q <= (action_e'(action_i) == ACT_FORK) ? '0 : wrap_inc(cur_q);
            state_q   <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          k_q <= k_q + 1'b1;
          if (proc_en && is_fork) begin
            if (fork_hit) begin
              found_q <= 1'b1;
              cand_q  <= proc_addr_q;
            end
            if (is_cur_pos) begin
              res_slot_q     <= cur_ext[2:0];
              res_no_run_q   <= !cur_running_q;
              res_fork_q     <= fork_found ? signed'(fork_idx_ext[3:0]) : FORK_NONE;
              res_switched_q <= 1'b0;
              state_q        <= S_DONE;
            end
          end else if (proc_en) begin
            if (!is_cur_pos) begin
              if ((st == ST_RUNNABLE) && !found_q) begin
                found_q      <= 1'b1;
                cand_q       <= proc_addr_q;
                cand_sleep_q <= sl;
              end
            end else begin
              cur_q          <= new_cur;
              cur_running_q  <= new_running;
              slice_q        <= do_switch ? '0 : slice_inc;
              res_slot_q     <= new_cur_ext[2:0];
              res_no_run_q   <= !new_running;
              res_fork_q     <= '0;
              res_switched_q <= new_switched;
              state_q        <= (do_switch && found_q) ? S_CAND : S_DONE;
            end
          end
        end
        S_CAND: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign running_slot_o = out_slot_q;
  assign no_runnable_o  = out_no_run_q;
  assign fork_result_o  = out_fork_q;
  assign switched_o     = out_switched_q;

  // configuration register
  assign cfg_write = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_ticks_q <= SLICE_TICKS_RST;
    end else if (cfg_write && (paddr[2] == REG_SLICE_TICKS)) begin
      slice_ticks_q <= pwdata[SLICE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SLICE_TICKS) begin
      prdata = {{(32 - SLICE_W){1'b0}}, slice_ticks_q};
    end
  end

  `RRSS_ASSERT(a_one_at_a_time, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `RRSS_ASSERT_ALWAYS(a_no_rw_collision, clk_i, (mem_we && mem_re) |-> (mem_waddr != rd_addr_q))
  `RRSS_ASSERT(a_slice_only_when_running, clk_i, rst_ni, (slice_q != '0) |-> cur_running_q)
  `RRSS_ASSERT(a_idle_never_switched, clk_i, rst_ni, (out_valid_o && no_runnable_o) |-> !switched_o)

endmodule
